### sv/htwd_pkg.sv
// Shared types and constants of the Huffman tree-walk decoder.
package htwd_pkg;

  localparam int IDX_W         = 9;
  localparam int SYM_W         = 8;
  localparam int BITS_PER_BYTE = 8;
  localparam int CNT_W         = $clog2(BITS_PER_BYTE);

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [SYM_W-1:0]         sym_t;
  typedef logic [BITS_PER_BYTE-1:0] code_t;

  // One node of the tree as it is kept in the table.
  typedef struct packed {
    idx_t left;
    idx_t right;
    logic leaf;
    sym_t symbol;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic rd_root;
    logic cap_root;
    logic step;
    logic drain;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_stale;
    logic stall;
    logic cur_leaf;
    logic flush_more;
  } sts_t;

endpackage

### sv/htwd_if.sv
// Channel interfaces of the decoder: input items, result items and configuration writes.
interface htwd_in_if;
  import htwd_pkg::*;
  logic  valid;
  logic  ready;
  logic  func;
  idx_t  node_index;
  idx_t  left_index;
  idx_t  right_index;
  logic  is_leaf;
  sym_t  leaf_symbol;
  code_t code_byte;

  modport source (
    output valid, func, node_index, left_index, right_index, is_leaf, leaf_symbol,
           code_byte,
    input  ready
  );
  modport sink (
    input  valid, func, node_index, left_index, right_index, is_leaf, leaf_symbol,
           code_byte,
    output ready
  );
endinterface

interface htwd_out_if;
  import htwd_pkg::*;
  logic valid;
  logic ready;
  sym_t symbol;
  logic last_of_byte;

  modport source (output valid, symbol, last_of_byte, input ready);
  modport sink (input valid, symbol, last_of_byte, output ready);
endinterface

interface htwd_cfg_if;
  import htwd_pkg::*;
  logic valid;
  logic ready;
  idx_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### sv/htwd_ctrl.sv
// Controller state machine of the decoder: sequences load, root fetch, bit steps, drain and flush.
module htwd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_ready,
  input  htwd_pkg::sts_t sts,
  output htwd_pkg::cmd_t cmd
);
  import htwd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROOT  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BITS_PER_BYTE - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            if (sts.root_stale) begin
              cmd.rd_root = 1'b1;
              state_nxt   = S_ROOT;
            end else begin
              state_nxt = S_STEP;
            end
          end
        end
      end
      S_ROOT: begin
        cmd.cap_root = 1'b1;
        state_nxt    = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (!sts.stall) begin
          if (sts.cur_leaf || cnt_r == CNT_LAST) begin
            state_nxt = S_DRAIN;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        if (!sts.stall) begin
          state_nxt = sts.flush_more ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (!sts.stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### sv/htwd_datapath.sv
// Datapath of the decoder: node table, walk pointer, root cache, pending symbol and output register.
module htwd_datapath #(
  parameter int NODE_COUNT = 512
) (
  input  logic            clk,
  input  logic            rst_n,
  input  htwd_pkg::cmd_t  cmd,
  output htwd_pkg::sts_t  sts,
  input  htwd_pkg::idx_t  in_node_index,
  input  htwd_pkg::idx_t  in_left_index,
  input  htwd_pkg::idx_t  in_right_index,
  input  logic            in_is_leaf,
  input  htwd_pkg::sym_t  in_leaf_symbol,
  input  htwd_pkg::code_t in_code_byte,
  input  logic            cfg_we,
  input  htwd_pkg::idx_t  cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output htwd_pkg::sym_t  out_symbol,
  output logic            out_last
);
  import htwd_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int WW = (AW > IDX_W) ? AW : IDX_W;

  function automatic logic [AW-1:0] to_addr(idx_t i);
    logic [WW-1:0] w;
    w = WW'(i);
    return w[AW-1:0];
  endfunction

  function automatic logic in_table(idx_t i);
    return 32'(i) < NODE_COUNT;
  endfunction

  entry_t mem [NODE_COUNT];

  idx_t   root_r, walk_r;
  entry_t root_ent_r, cur_ent_r, rd_q_r;
  logic   rd_zero_r, rd_live_r, stale_r;
  code_t  byte_r;
  logic   pend_vld_r;
  sym_t   pend_sym_r;
  logic   out_vld_r, out_last_r;
  sym_t   out_sym_r;

  entry_t rd_ent, cur_eff, wr_ent;
  idx_t   walk_eff, next_idx, rd_idx;
  logic   rd_leaf, push, push_last, stall, go, rd_en;
  sym_t   push_sym;

  assign rd_ent   = rd_zero_r ? entry_t'('0) : rd_q_r;
  assign rd_leaf  = rd_live_r && rd_ent.leaf;
  // After a leaf the walk is back at the root, so the cached root node stands in.
  assign cur_eff  = rd_live_r ? (rd_ent.leaf ? root_ent_r : rd_ent) : cur_ent_r;
  assign walk_eff = rd_leaf ? root_r : walk_r;
  assign next_idx = byte_r[BITS_PER_BYTE-1] ? cur_eff.right : cur_eff.left;

  assign wr_ent = '{left: in_left_index, right: in_right_index, leaf: in_is_leaf,
                    symbol: in_leaf_symbol};

  // A symbol is held back until the next one or the end of the byte shows whether it is last.
  always_comb begin
    push      = 1'b0;
    push_sym  = pend_sym_r;
    push_last = 1'b0;
    if (cmd.step) begin
      push = rd_leaf && pend_vld_r;
    end else if (cmd.drain) begin
      if (rd_leaf) begin
        push = 1'b1;
        if (!pend_vld_r) begin
          push_sym  = rd_ent.symbol;
          push_last = 1'b1;
        end
      end else begin
        push      = pend_vld_r;
        push_last = 1'b1;
      end
    end else if (cmd.flush) begin
      push      = pend_vld_r;
      push_last = 1'b1;
    end
  end

  assign stall  = push && out_vld_r && !out_ready;
  assign go     = !stall;
  assign rd_en  = cmd.rd_root || (cmd.step && go && !cur_eff.leaf);
  assign rd_idx = cmd.rd_root ? root_r : next_idx;

  assign sts.root_stale = stale_r;
  assign sts.stall      = stall;
  assign sts.cur_leaf   = cur_eff.leaf;
  assign sts.flush_more = rd_leaf && pend_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.load && in_table(in_node_index)) begin
      mem[to_addr(in_node_index)] <= wr_ent;
    end
    if (rd_en) begin
      if (in_table(rd_idx)) begin
        rd_q_r <= mem[to_addr(rd_idx)];
      end
      rd_zero_r <= !in_table(rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r     <= '0;
      walk_r     <= '0;
      stale_r    <= 1'b1;
      rd_live_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        root_r  <= cfg_data;
        walk_r  <= cfg_data;
        stale_r <= 1'b1;
      end
      if (cmd.load) begin
        walk_r    <= root_r;
        cur_ent_r <= root_ent_r;
        if (in_node_index == root_r) begin
          stale_r <= 1'b1;
        end
      end
      if (cmd.start) begin
        byte_r <= in_code_byte;
      end
      if (cmd.cap_root) begin
        root_ent_r <= rd_ent;
        cur_ent_r  <= rd_ent;
        stale_r    <= 1'b0;
      end
      if (cmd.step && go) begin
        if (cur_eff.leaf) begin
          walk_r    <= walk_eff;
          cur_ent_r <= cur_eff;
          rd_live_r <= 1'b0;
        end else begin
          walk_r    <= next_idx;
          rd_live_r <= 1'b1;
          byte_r    <= {byte_r[BITS_PER_BYTE-2:0], 1'b0};
        end
        if (rd_leaf) begin
          pend_vld_r <= 1'b1;
          pend_sym_r <= rd_ent.symbol;
        end
      end
      if (cmd.drain && go) begin
        walk_r    <= walk_eff;
        cur_ent_r <= cur_eff;
        rd_live_r <= 1'b0;
        if (rd_leaf && pend_vld_r) begin
          pend_sym_r <= rd_ent.symbol;
        end else begin
          pend_vld_r <= 1'b0;
        end
      end
      if (cmd.flush && go) begin
        pend_vld_r <= 1'b0;
      end
      if (push && go) begin
        out_vld_r  <= 1'b1;
        out_sym_r  <= push_sym;
        out_last_r <= push_last;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_vld_r;
  assign out_symbol = out_sym_r;
  assign out_last   = out_last_r;

endmodule

### sv/huffman_tree_walk_decoder_unit.sv
// Top level of the Huffman tree-walk decoder: controller, datapath and channel wiring.
// A load item is taken in the idle state. A decode item passes the accept state, eight bit
// steps at one dependent node-table read each and a drain state; a leaf as root ends the steps at once.
// A root fetch state is added after a configuration write or a load into the root slot,
// and a flush state passes on a held symbol when the final bit lands on a leaf; a full output stalls.
// Reset is synchronous and active low; the node table is not cleared and is undefined until written.
module huffman_tree_walk_decoder_unit #(
  parameter int NODE_COUNT = 512
) (
  input logic        clk,
  input logic        rst_n,
  htwd_in_if.sink    in_ch,
  htwd_out_if.source out_ch,
  htwd_cfg_if.sink   cfg_ch
);
  import htwd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns the input handshake; only one item is worked on at a time.
  htwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Configuration writes are always taken; the user must send them only while the decoder is idle (unenforced).
  assign cfg_ch.ready = 1'b1;

  // The datapath walks the tree one code bit per cycle unless the output stalls, and holds each symbol until the
  // next symbol or the end of the byte decides its last-of-byte flag.
  htwd_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_node_index  (in_ch.node_index),
    .in_left_index  (in_ch.left_index),
    .in_right_index (in_ch.right_index),
    .in_is_leaf     (in_ch.is_leaf),
    .in_leaf_symbol (in_ch.leaf_symbol),
    .in_code_byte   (in_ch.code_byte),
    .cfg_we         (cfg_ch.valid),
    .cfg_data       (cfg_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_symbol     (out_ch.symbol),
    .out_last       (out_ch.last_of_byte)
  );

endmodule

### sv/htwd_checker.sv
// Port-level checker of the decoder and its bind to the top level.
module htwd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_func,
  input logic           out_valid,
  input logic           out_ready,
  input htwd_pkg::sym_t out_symbol,
  input logic           out_last
);
  import htwd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_symbol) && $stable(out_last))
    else $error("result item changed while stalled");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_LOAD && !out_valid |=> !out_valid)
    else $error("load item produced a result item");

  a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_DECODE |=> !in_ready)
    else $error("input taken right after a decode item");

endmodule

bind huffman_tree_walk_decoder_unit htwd_checker u_htwd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_func    (in_ch.func),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_symbol (out_ch.symbol),
  .out_last   (out_ch.last_of_byte)
);

### test/tb.sv
// Self-checking testbench of the Huffman tree-walk decoder: a directed tree, then random trees, code bytes and stalls.
import htwd_pkg::*;

// One input item as the monitor sees it on the input channel.
typedef struct {
  logic  func;
  idx_t  node_index;
  idx_t  left_index;
  idx_t  right_index;
  logic  is_leaf;
  sym_t  leaf_symbol;
  code_t code_byte;
} node_cmd_t;

// One decoded symbol as it is expected on the result channel.
typedef struct {
  sym_t symbol;
  logic last_of_byte;
} sym_result_t;

// Mirror of the decoder: its own node table, root and walk position, and the
// symbols still owed on the result channel, oldest first.
class tree_walk_model;
  entry_t      nodes [512];
  idx_t        root;
  idx_t        walk;
  sym_result_t pending_symbols [$];
  int          errors;

  function new();
    root   = '0;
    walk   = '0;
    errors = 0;
  endfunction

  task flag_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function void write_root(idx_t value);
    root = value;
    walk = value;
  endfunction

  function int pending();
    return pending_symbols.size();
  endfunction

  // Applies one accepted item and queues the symbols that it yields.
  function void accept_item(node_cmd_t it);
    entry_t      cur;
    entry_t      nxt;
    code_t       bits;
    int          produced;
    sym_result_t r;
    if (it.func == FUNC_LOAD) begin
      nodes[it.node_index].left   = it.left_index;
      nodes[it.node_index].right  = it.right_index;
      nodes[it.node_index].leaf   = it.is_leaf;
      nodes[it.node_index].symbol = it.leaf_symbol;
      walk = root;
      return;
    end
    bits     = it.code_byte;
    produced = 0;
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      cur = nodes[walk];
      // Standing on a leaf (only possible when the root is one) drops the rest of the byte.
      if (cur.leaf) break;
      walk = bits[BITS_PER_BYTE-1] ? cur.right : cur.left;
      bits = bits << 1;
      nxt  = nodes[walk];
      if (nxt.leaf) begin
        r.symbol       = nxt.symbol;
        r.last_of_byte = 1'b0;
        pending_symbols.push_back(r);
        produced++;
        walk = root;
      end
    end
    if (produced > 0) begin
      r = pending_symbols.pop_back();
      r.last_of_byte = 1'b1;
      pending_symbols.push_back(r);
    end
  endfunction

  task check_symbol(sym_t sym, logic last);
    sym_result_t want;
    if (pending_symbols.size() == 0) begin
      flag_mismatch($sformatf("symbol %h (last %b) with none expected", sym, last));
      return;
    end
    want = pending_symbols.pop_front();
    if (sym !== want.symbol)
      flag_mismatch($sformatf("symbol %h, expected %h", sym, want.symbol));
    if (last !== want.last_of_byte)
      flag_mismatch($sformatf("last_of_byte %b, expected %b on symbol %h",
                              last, want.last_of_byte, want.symbol));
  endtask
endclass

module tb;
  localparam int NODES      = 512;
  // Cycles to let pass after the last symbol, covering a decode item in flight
  // that yields nothing plus the root fetch and the output register.
  localparam int SETTLE     = 16;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF   = 300;

  logic clk;
  logic rst_n;

  htwd_in_if  in_ch ();
  htwd_out_if out_ch ();
  htwd_cfg_if cfg_ch ();

  huffman_tree_walk_decoder_unit #(.NODE_COUNT(NODES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tree_walk_model walker = new();

  // Slots that the stimulus has loaded; internal nodes only ever point at these,
  // so no walk can reach an entry that was never written.
  bit   written [NODES];
  int   send_idle;
  int   recv_idle;
  int   hold_left;
  int   quiet_cycles;
  logic moved;
  node_cmd_t seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result receiver: random back-pressure, or a long hold-off when requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Monitor: every handshake is seen here with pre-edge values, which keeps the
  // order of configuration writes, input items and results exact.
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        walker.write_root(cfg_ch.data);
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.func        = in_ch.func;
        seen.node_index  = in_ch.node_index;
        seen.left_index  = in_ch.left_index;
        seen.right_index = in_ch.right_index;
        seen.is_leaf     = in_ch.is_leaf;
        seen.leaf_symbol = in_ch.leaf_symbol;
        seen.code_byte   = in_ch.code_byte;
        walker.accept_item(seen);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        walker.check_symbol(out_ch.symbol, out_ch.last_of_byte);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic idx_t rand_idx();
    return idx_t'($urandom_range(NODES - 1));
  endfunction

  function automatic idx_t rand_written();
    idx_t v;
    do v = rand_idx(); while (!written[v]);
    return v;
  endfunction

  // Offers one item, with a random gap in front, and returns at its acceptance.
  // Valid stays high afterwards so back-to-back items need no toggle.
  task automatic send(node_cmd_t it);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.func        <= it.func;
    in_ch.node_index  <= it.node_index;
    in_ch.left_index  <= it.left_index;
    in_ch.right_index <= it.right_index;
    in_ch.is_leaf     <= it.is_leaf;
    in_ch.leaf_symbol <= it.leaf_symbol;
    in_ch.code_byte   <= it.code_byte;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic load_node(idx_t slot, idx_t left, idx_t right, logic leaf, sym_t sym);
    node_cmd_t it;
    it.func        = FUNC_LOAD;
    it.node_index  = slot;
    it.left_index  = left;
    it.right_index = right;
    it.is_leaf     = leaf;
    it.leaf_symbol = sym;
    it.code_byte   = code_t'($urandom_range(255));
    written[slot]  = 1'b1;
    send(it);
  endtask

  // The load fields carry random bits, which a decode item must ignore.
  task automatic decode_byte(code_t code);
    node_cmd_t it;
    it.func        = FUNC_DECODE;
    it.node_index  = rand_idx();
    it.left_index  = rand_idx();
    it.right_index = rand_idx();
    it.is_leaf     = 1'($urandom_range(1));
    it.leaf_symbol = sym_t'($urandom_range(255));
    it.code_byte   = code;
    send(it);
  endtask

  // A leaf anywhere, or an internal node whose children are already loaded.
  task automatic load_random_node();
    if ($urandom_range(1) == 1)
      load_node(rand_idx(), rand_idx(), rand_idx(), 1'b1, sym_t'($urandom_range(255)));
    else
      load_node(rand_idx(), rand_written(), rand_written(), 1'b0,
                sym_t'($urandom_range(255)));
  endtask

  // Loads a fresh tree bottom-up into random slots and hands back its root.
  task automatic build_tree(input int leaves, output idx_t top);
    idx_t subtrees [$];
    idx_t a;
    idx_t b;
    idx_t slot;
    for (int k = 0; k < leaves; k++) begin
      slot = rand_idx();
      load_node(slot, rand_idx(), rand_idx(), 1'b1, sym_t'($urandom_range(255)));
      subtrees.push_back(slot);
    end
    while (subtrees.size() > 1) begin
      a = subtrees.pop_front();
      b = subtrees.pop_front();
      slot = rand_idx();
      if ($urandom_range(1) == 1) load_node(slot, a, b, 1'b0, sym_t'($urandom_range(255)));
      else load_node(slot, b, a, 1'b0, sym_t'($urandom_range(255)));
      subtrees.push_back(slot);
    end
    top = subtrees[0];
  endtask

  // Stops offering items until every owed symbol has arrived and the block has
  // had time to finish a byte that yields nothing.
  task automatic drain_decoder();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (walker.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only called with the decoder idle, and only with a slot that was loaded.
  task automatic write_root(idx_t value);
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    idx_t top;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FUNC_LOAD;
    in_ch.node_index  <= '0;
    in_ch.left_index  <= '0;
    in_ch.right_index <= '0;
    in_ch.is_leaf     <= 1'b0;
    in_ch.leaf_symbol <= '0;
    in_ch.code_byte   <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    rst_n             <= 1'b0;
    send_idle    = 36;
    recv_idle    = 72;
    hold_left    = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset root, slot 0. Leaves 1 and 3 carry extreme child fields,
    // and slot 511 exercises the top of the table.
    load_node(9'd1,   9'd511, 9'd0,   1'b1, 8'h00);
    load_node(9'd3,   9'd0,   9'd511, 1'b1, 8'hFF);
    load_node(9'd511, 9'h155, 9'h0AA, 1'b1, 8'hA5);
    load_node(9'd2,   9'd3,   9'd511, 1'b0, 8'h5A);
    load_node(9'd0,   9'd1,   9'd2,   1'b0, 8'h00);
    decode_byte(8'h00);   // eight symbols from one byte
    decode_byte(8'hFF);   // only right turns
    decode_byte(8'h01);   // ends mid-walk, so the walk carries into the next byte
    decode_byte(8'h7F);   // finishes the carried walk and ends mid-walk again
    load_node(9'd4,   9'd1,   9'd3,   1'b0, 8'hC3);   // a load sends the walk home
    decode_byte(8'h80);
    load_node(9'd0,   9'd4,   9'd2,   1'b0, 8'h3C);   // rewrite the root slot itself
    decode_byte(8'hA5);
    decode_byte(8'h5A);
    drain_decoder();
    // A leaf as root: bytes are swallowed without any symbol.
    write_root(9'd511);
    decode_byte(8'hFF);
    decode_byte(8'h00);
    drain_decoder();
    write_root(9'd3);
    decode_byte(8'h96);
    drain_decoder();
    write_root(9'd2);
    decode_byte(8'hC3);
    decode_byte(8'h3C);
    drain_decoder();
    write_root(9'd0);
    decode_byte(8'h69);

    // Random part in three idling regimes, each on a tree of its own.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 36;
          recv_idle = 72;
        end
        1: begin
          send_idle = 72;
          recv_idle = 36;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      build_tree($urandom_range(2, 9), top);
      drain_decoder();
      write_root(top);
      for (int n = 0; n < 75; n++) begin
        // With the sender never idle, a long receiver hold-off fills the block
        // and pushes back on the input channel.
        if (ph == 2 && n == 10) hold_left = HOLD_OFF;
        // Halfway through, go quiet until everything is out, then move the root.
        if (n == 40) begin
          drain_decoder();
          write_root(rand_written());
        end
        if ($urandom_range(99) < 80) decode_byte(code_t'($urandom_range(255)));
        else load_random_node();
      end
    end

    drain_decoder();
    if (walker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
